/* hw/rtl/ecif_pkg.sv */
// ----------------------------------------------------------------------------
// ecif_pkg
// Shared types, codes, saturation and halving helpers for the Euler interface flux block.
// ----------------------------------------------------------------------------
package ecif_pkg;

   localparam int DATA_W      = 48;
   localparam int FUNC_W      = 2;
   localparam int GAMMA_W     = 26;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;
   localparam int MUL_DIG_W   = 16;
   localparam int MUL_STEPS   = 3;
   localparam int MUL_CNT_W   = 2;

   localparam logic [GAMMA_W-1:0] GAMMA_RESET = 26'd23488102;

   localparam logic [FUNC_W-1:0] FUNC_LEFT  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_CELL  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_RIGHT = 2'd2;

   localparam logic signed [DATA_W-1:0] POS_LIM = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] NEG_LIM = {1'b1, {(DATA_W-1){1'b0}}};

   typedef enum logic {
      JOB_BOUNDARY,
      JOB_FACE
   } job_kind_type;

   typedef enum logic {
      OP_MUL,
      OP_DIV
   } arith_op_type;

   typedef struct packed {
      job_kind_type              kind;
      logic signed [DATA_W-1:0] a;
      logic signed [DATA_W-1:0] b;
      logic signed [DATA_W-1:0] c;
   } job_type;

   typedef struct packed {
      logic    push;
      job_type job;
   } queue_wr_type;

   typedef struct packed {
      logic    avail;
      job_type job;
   } queue_rd_type;

   typedef struct packed {
      logic                      start;
      arith_op_type              op;
      logic signed [DATA_W-1:0] a;
      logic signed [DATA_W-1:0] b;
   } arith_req_type;

   typedef struct packed {
      logic                      done;
      logic signed [DATA_W-1:0] result;
   } arith_rsp_type;

   // clamp a magnitude to the signed range and apply the sign
   function automatic logic signed [DATA_W-1:0] sat_mag(input logic neg, input logic over,
                                                        input logic [DATA_W-1:0] lo);
      logic [DATA_W-1:0] lim;
      logic [DATA_W-1:0] m;
      lim = neg ? NEG_LIM : POS_LIM;
      m   = (over || (lo > lim)) ? lim : lo;
      return neg ? -m : m;
   endfunction

   function automatic logic signed [DATA_W-1:0] sat_sum(input logic signed [DATA_W:0] x);
      logic signed [DATA_W-1:0] r;
      if (x[DATA_W] != x[DATA_W-1]) begin
         r = x[DATA_W] ? NEG_LIM : POS_LIM;
      end else begin
         r = x[DATA_W-1:0];
      end
      return r;
   endfunction

   // halve, rounding toward zero
   function automatic logic signed [DATA_W-1:0] half48(input logic signed [DATA_W-1:0] x);
      logic signed [DATA_W:0] t;
      t = {x[DATA_W-1], x} + {{DATA_W{1'b0}}, x[DATA_W-1]};
      return t[DATA_W:1];
   endfunction

   function automatic logic signed [DATA_W-1:0] half49(input logic signed [DATA_W:0] x);
      logic signed [DATA_W+1:0] t;
      t = {x[DATA_W], x} + {{(DATA_W+1){1'b0}}, x[DATA_W]};
      return t[DATA_W:1];
   endfunction

endpackage

/* hw/rtl/ecif_if.sv */
// ----------------------------------------------------------------------------
// ecif channels
// Valid/ready channels for boundary and cell beats in and flux beats out.
// ----------------------------------------------------------------------------
interface ecif_req_if;
   logic                                     valid;
   logic                                     ready;
   logic [ecif_pkg::FUNC_W-1:0]              func;
   logic signed [ecif_pkg::DATA_W-1:0]       value_a;
   logic signed [ecif_pkg::DATA_W-1:0]       value_b;
   logic signed [ecif_pkg::DATA_W-1:0]       value_c;

   modport source (output valid, func, value_a, value_b, value_c, input ready);
   modport sink   (input valid, func, value_a, value_b, value_c, output ready);
endinterface

interface ecif_rsp_if;
   logic                                     valid;
   logic                                     ready;
   logic signed [ecif_pkg::DATA_W-1:0]       mass_flux;
   logic signed [ecif_pkg::DATA_W-1:0]       momentum_flux;
   logic signed [ecif_pkg::DATA_W-1:0]       energy_flux;
   logic                                     density_fault;

   modport source (output valid, mass_flux, momentum_flux, energy_flux, density_fault,
                   input ready);
   modport sink   (input valid, mass_flux, momentum_flux, energy_flux, density_fault,
                   output ready);
endinterface

/* hw/rtl/ecif_front.sv */
// ----------------------------------------------------------------------------
// ecif_front
// Accepts beats, keeps the previous cell and queues boundary and face jobs.
// ----------------------------------------------------------------------------
module ecif_front (
   input  logic                   clock,
   input  logic                   reset,
   ecif_req_if.sink               req,
   input  logic                   queue_full,
   output ecif_pkg::queue_wr_type qwr
);

   logic signed [ecif_pkg::DATA_W-1:0] prior_ff [3];
   logic                               prior_valid_ff;
   logic                               accept;

   assign req.ready = !queue_full;
   assign accept    = req.valid && req.ready;

   always_comb begin
      qwr.push     = 1'b0;
      qwr.job.kind = ecif_pkg::JOB_BOUNDARY;
      qwr.job.a    = req.value_a;
      qwr.job.b    = req.value_b;
      qwr.job.c    = req.value_c;
      if (accept) begin
         unique case (req.func) inside
            ecif_pkg::FUNC_LEFT, ecif_pkg::FUNC_RIGHT: begin
               qwr.push = 1'b1;
            end
            ecif_pkg::FUNC_CELL: begin
               qwr.push     = prior_valid_ff;
               qwr.job.kind = ecif_pkg::JOB_FACE;
               qwr.job.a    = ecif_pkg::half49({req.value_a[47], req.value_a}
                                               + {prior_ff[0][47], prior_ff[0]});
               qwr.job.b    = ecif_pkg::half49({req.value_b[47], req.value_b}
                                               + {prior_ff[1][47], prior_ff[1]});
               qwr.job.c    = ecif_pkg::half49({req.value_c[47], req.value_c}
                                               + {prior_ff[2][47], prior_ff[2]});
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prior_valid_ff <= 1'b0;
         prior_ff[0]    <= '0;
         prior_ff[1]    <= '0;
         prior_ff[2]    <= '0;
      end else if (accept) begin
         if (req.func == ecif_pkg::FUNC_CELL) begin
            prior_valid_ff <= 1'b1;
            prior_ff[0]    <= req.value_a;
            prior_ff[1]    <= req.value_b;
            prior_ff[2]    <= req.value_c;
         end else if (req.func == ecif_pkg::FUNC_LEFT || req.func == ecif_pkg::FUNC_RIGHT) begin
            prior_valid_ff <= 1'b0;
         end
      end
   end

endmodule

/* hw/rtl/ecif_queue.sv */
// ----------------------------------------------------------------------------
// ecif_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
module ecif_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  ecif_pkg::queue_wr_type qwr,
   output logic                   full,
   input  logic                   pop,
   output ecif_pkg::queue_rd_type qrd
);

   ecif_pkg::job_type                entry_ff [ecif_pkg::QUEUE_DEPTH];
   logic [ecif_pkg::QPTR_W-1:0]      wr_ptr_ff;
   logic [ecif_pkg::QPTR_W-1:0]      rd_ptr_ff;
   logic [ecif_pkg::QCNT_W-1:0]      count_ff;
   logic                             do_pop;

   assign full      = (count_ff == ecif_pkg::QCNT_W'(ecif_pkg::QUEUE_DEPTH));
   assign qrd.avail = (count_ff != '0);
   assign qrd.job   = entry_ff[rd_ptr_ff];
   assign do_pop    = pop && qrd.avail;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (qwr.push) begin
            entry_ff[wr_ptr_ff] <= qwr.job;
            wr_ptr_ff           <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (qwr.push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (!qwr.push && do_pop) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

/* hw/rtl/ecif_arith.sv */
// ----------------------------------------------------------------------------
// ecif_arith
// Shared fixed-point unit: digit-serial multiply and bit-serial restoring divide.
// ----------------------------------------------------------------------------
module ecif_arith #(
   parameter int FRAC_BITS = 24
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ecif_pkg::arith_req_type areq,
   output ecif_pkg::arith_rsp_type arsp
);

   localparam int DW     = ecif_pkg::DATA_W;
   localparam int NUM_W  = DW + FRAC_BITS;
   localparam int PROD_W = 2 * DW;
   localparam int DCNT_W = $clog2(NUM_W);

   typedef enum logic [2:0] {
      A_IDLE,
      A_MUL,
      A_MFIN,
      A_DIV,
      A_DFIN
   } astate_type;

   astate_type                  state_ff;
   logic                        neg_ff;
   logic [DW-1:0]               ma_ff;
   logic [DW-1:0]               mb_ff;
   logic [PROD_W-1:0]           prod_ff;
   logic [ecif_pkg::MUL_CNT_W-1:0] mcnt_ff;
   logic [NUM_W-1:0]            num_ff;
   logic [NUM_W-1:0]            quo_ff;
   logic [DW-1:0]               rem_ff;
   logic [DCNT_W-1:0]           dcnt_ff;
   logic                        done_ff;
   logic signed [DW-1:0]        result_ff;

   logic [DW-1:0]               mag_a;
   logic [DW-1:0]               mag_b;
   logic [PROD_W-1:0]           prod_in;
   logic [PROD_W-1:0]           shifted;
   logic [DW:0]                 trial;
   logic                        ge;
   logic [DW-1:0]               rem_in;

   assign mag_a   = areq.a[DW-1] ? -areq.a : areq.a;
   assign mag_b   = areq.b[DW-1] ? -areq.b : areq.b;
   assign prod_in = (prod_ff << ecif_pkg::MUL_DIG_W)
                    + PROD_W'({{ecif_pkg::MUL_DIG_W{1'b0}}, ma_ff}
                              * mb_ff[DW-1 -: ecif_pkg::MUL_DIG_W]);
   assign shifted = prod_ff >> FRAC_BITS;
   assign trial   = {rem_ff, num_ff[NUM_W-1]};
   assign ge      = (trial >= {1'b0, mb_ff});
   assign rem_in  = ge ? DW'(trial - {1'b0, mb_ff}) : trial[DW-1:0];

   assign arsp.done   = done_ff;
   assign arsp.result = result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            A_IDLE: begin
               if (areq.start) begin
                  neg_ff <= areq.a[DW-1] ^ areq.b[DW-1];
                  ma_ff  <= mag_a;
                  mb_ff  <= mag_b;
                  if (areq.op == ecif_pkg::OP_MUL) begin
                     prod_ff  <= '0;
                     mcnt_ff  <= '0;
                     state_ff <= A_MUL;
                  end else if (areq.b == '0) begin
                     // divide by zero saturates toward the numerator's sign
                     result_ff <= areq.a[DW-1] ? ecif_pkg::NEG_LIM :
                                  ((areq.a == '0) ? '0 : ecif_pkg::POS_LIM);
                     done_ff   <= 1'b1;
                  end else begin
                     num_ff   <= NUM_W'(mag_a) << FRAC_BITS;
                     quo_ff   <= '0;
                     rem_ff   <= '0;
                     dcnt_ff  <= DCNT_W'(NUM_W - 1);
                     state_ff <= A_DIV;
                  end
               end
            end
            A_MUL: begin
               prod_ff <= prod_in;
               mb_ff   <= mb_ff << ecif_pkg::MUL_DIG_W;
               mcnt_ff <= mcnt_ff + 1'b1;
               if (mcnt_ff == ecif_pkg::MUL_CNT_W'(ecif_pkg::MUL_STEPS - 1)) begin
                  state_ff <= A_MFIN;
               end
            end
            A_MFIN: begin
               result_ff <= ecif_pkg::sat_mag(neg_ff, |shifted[PROD_W-1:DW], shifted[DW-1:0]);
               done_ff   <= 1'b1;
               state_ff  <= A_IDLE;
            end
            A_DIV: begin
               rem_ff  <= rem_in;
               num_ff  <= num_ff << 1;
               quo_ff  <= {quo_ff[NUM_W-2:0], ge};
               dcnt_ff <= dcnt_ff - 1'b1;
               if (dcnt_ff == '0) begin
                  state_ff <= A_DFIN;
               end
            end
            A_DFIN: begin
               result_ff <= ecif_pkg::sat_mag(neg_ff, |quo_ff[NUM_W-1:DW], quo_ff[DW-1:0]);
               done_ff   <= 1'b1;
               state_ff  <= A_IDLE;
            end
            default: begin
               state_ff <= A_IDLE;
            end
         endcase
      end
   end

endmodule

/* hw/rtl/ecif_back.sv */
// ----------------------------------------------------------------------------
// ecif_back
// Sequencer that turns a queued job into a face flux using the shared unit.
// ----------------------------------------------------------------------------
module ecif_back #(
   parameter int FRAC_BITS = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [ecif_pkg::GAMMA_W-1:0]      gamma,
   input  ecif_pkg::queue_rd_type            qrd,
   output logic                              pop,
   ecif_rsp_if.source                        rsp
);

   localparam int DW = ecif_pkg::DATA_W;
   localparam logic signed [DW-1:0] ONE = DW'(1) << FRAC_BITS;

   typedef enum logic [3:0] {
      S_IDLE,
      S_B_MOM,
      S_B_KE,
      S_B_PDIV,
      S_F_CHECK,
      S_F_U,
      S_F_Q,
      S_F_T1,
      S_F_T2,
      S_F_T3,
      S_F_T4,
      S_F_T5,
      S_OUT
   } bstate_type;

   bstate_type              state_ff;
   logic                    issued_ff;
   logic signed [DW-1:0]    r_ff;
   logic signed [DW-1:0]    m_ff;
   logic signed [DW-1:0]    e_ff;
   logic signed [DW-1:0]    v_ff;
   logic signed [DW-1:0]    p_ff;
   logic signed [DW-1:0]    u_ff;
   logic signed [DW-1:0]    q_ff;
   logic signed [DW-1:0]    t_ff;
   logic signed [DW-1:0]    inner_ff;
   logic signed [DW-1:0]    f1_ff;
   logic signed [DW-1:0]    f2_ff;
   logic                    fault_ff;
   logic                    rsp_valid_ff;
   logic signed [DW-1:0]    rsp_mass_ff;
   logic signed [DW-1:0]    rsp_mom_ff;
   logic signed [DW-1:0]    rsp_energy_ff;
   logic                    rsp_fault_ff;

   logic signed [DW-1:0]    gam;
   logic signed [DW-1:0]    c3;
   logic signed [DW-1:0]    g1;
   logic signed [DW-1:0]    gh;
   logic                    computing;
   ecif_pkg::arith_req_type areq;
   ecif_pkg::arith_rsp_type arsp;
   logic signed [DW-1:0]    res;

   assign gam = DW'(gamma);
   assign c3  = ecif_pkg::half48((ONE <<< 1) + ONE - gam);
   assign g1  = gam - ONE;
   assign gh  = ecif_pkg::half48(g1);
   assign res = arsp.result;

   assign pop = (state_ff == S_IDLE) && qrd.avail;

   always_comb begin
      computing = 1'b1;
      areq.op   = ecif_pkg::OP_MUL;
      areq.a    = '0;
      areq.b    = '0;
      unique case (state_ff)
         S_B_MOM:  begin areq.a = r_ff; areq.b = v_ff; end
         S_B_KE:   begin areq.a = m_ff; areq.b = v_ff; end
         S_B_PDIV: begin areq.op = ecif_pkg::OP_DIV; areq.a = p_ff; areq.b = g1; end
         S_F_U:    begin areq.op = ecif_pkg::OP_DIV; areq.a = m_ff; areq.b = r_ff; end
         S_F_Q:    begin areq.a = m_ff; areq.b = u_ff; end
         S_F_T1:   begin areq.a = c3; areq.b = q_ff; end
         S_F_T2:   begin areq.a = g1; areq.b = e_ff; end
         S_F_T3:   begin areq.a = gh; areq.b = q_ff; end
         S_F_T4:   begin areq.a = e_ff; areq.b = u_ff; end
         S_F_T5:   begin areq.a = u_ff; areq.b = inner_ff; end
         default:  begin computing = 1'b0; end
      endcase
      areq.start = computing && !issued_ff;
   end

   ecif_arith #(
      .FRAC_BITS (FRAC_BITS)
   ) u_arith (
      .clock (clock),
      .reset (reset),
      .areq  (areq),
      .arsp  (arsp)
   );

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.mass_flux     = rsp_mass_ff;
   assign rsp.momentum_flux = rsp_mom_ff;
   assign rsp.energy_flux   = rsp_energy_ff;
   assign rsp.density_fault = rsp_fault_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // in S_OUT the output register is reloaded below instead
         if (rsp_valid_ff && rsp.ready && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         if (areq.start) begin
            issued_ff <= 1'b1;
         end
         if (arsp.done) begin
            issued_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (qrd.avail) begin
                  r_ff <= qrd.job.a;
                  if (qrd.job.kind == ecif_pkg::JOB_FACE) begin
                     m_ff     <= qrd.job.b;
                     e_ff     <= qrd.job.c;
                     state_ff <= S_F_CHECK;
                  end else begin
                     v_ff     <= qrd.job.b;
                     p_ff     <= qrd.job.c;
                     state_ff <= S_B_MOM;
                  end
               end
            end
            S_B_MOM: if (arsp.done) begin
               m_ff     <= res;
               state_ff <= S_B_KE;
            end
            S_B_KE: if (arsp.done) begin
               // kinetic energy parked in e until the pressure term arrives
               e_ff     <= ecif_pkg::half48(res);
               state_ff <= S_B_PDIV;
            end
            S_B_PDIV: if (arsp.done) begin
               e_ff     <= ecif_pkg::sat_sum({res[DW-1], res} + {e_ff[DW-1], e_ff});
               state_ff <= S_F_CHECK;
            end
            S_F_CHECK: begin
               if (r_ff[DW-1] || r_ff == '0) begin
                  fault_ff <= 1'b1;
                  f1_ff    <= '0;
                  f2_ff    <= '0;
                  state_ff <= S_OUT;
               end else begin
                  fault_ff <= 1'b0;
                  state_ff <= S_F_U;
               end
            end
            S_F_U: if (arsp.done) begin
               u_ff     <= res;
               state_ff <= S_F_Q;
            end
            S_F_Q: if (arsp.done) begin
               q_ff     <= res;
               state_ff <= S_F_T1;
            end
            S_F_T1: if (arsp.done) begin
               t_ff     <= res;
               state_ff <= S_F_T2;
            end
            S_F_T2: if (arsp.done) begin
               f1_ff    <= ecif_pkg::sat_sum({t_ff[DW-1], t_ff} + {res[DW-1], res});
               t_ff     <= res;
               state_ff <= S_F_T3;
            end
            S_F_T3: if (arsp.done) begin
               inner_ff <= ecif_pkg::sat_sum({t_ff[DW-1], t_ff} - {res[DW-1], res});
               state_ff <= S_F_T4;
            end
            S_F_T4: if (arsp.done) begin
               t_ff     <= res;
               state_ff <= S_F_T5;
            end
            S_F_T5: if (arsp.done) begin
               f2_ff    <= ecif_pkg::sat_sum({t_ff[DW-1], t_ff} + {res[DW-1], res});
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp.ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_mass_ff   <= m_ff;
                  rsp_mom_ff    <= f1_ff;
                  rsp_energy_ff <= f2_ff;
                  rsp_fault_ff  <= fault_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

/* hw/rtl/euler_central_interface_flux.sv */
// ----------------------------------------------------------------------------
// euler_central_interface_flux
// Inviscid 1-D Euler flux at each cell face from a stream of boundary and
// cell beats, signed fixed point with FRAC_BITS fraction bits, saturating.
// ----------------------------------------------------------------------------
// The front takes a beat whenever its two-entry job queue has room, so input
// and output stall independently. Faces are computed one at a time by a single
// shared multiply/divide unit: a multiply runs three 48x16 digit steps, a
// divide produces one quotient bit per cycle. An interior face costs one
// divide and six multiplies; a boundary face adds two multiplies and a
// divide. A face with non-positive density skips the face arithmetic and is
// flagged with a density fault. A first cell after reset or after a boundary
// beat gives no result.
module euler_central_interface_flux #(
   parameter int FRAC_BITS = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   ecif_req_if.sink                     req,
   ecif_rsp_if.source                   rsp,
   input  logic                         csr_we,
   input  logic [ecif_pkg::GAMMA_W-1:0] csr_wdata
);

   logic [ecif_pkg::GAMMA_W-1:0] gamma_ff;
   ecif_pkg::queue_wr_type       qwr;
   ecif_pkg::queue_rd_type       qrd;
   logic                         queue_full;
   logic                         pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         gamma_ff <= ecif_pkg::GAMMA_RESET;
      end else if (csr_we) begin
         gamma_ff <= csr_wdata;
      end
   end

   ecif_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .queue_full (queue_full),
      .qwr        (qwr)
   );

   ecif_queue u_queue (
      .clock (clock),
      .reset (reset),
      .qwr   (qwr),
      .full  (queue_full),
      .pop   (pop),
      .qrd   (qrd)
   );

   ecif_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock (clock),
      .reset (reset),
      .gamma (gamma_ff),
      .qrd   (qrd),
      .pop   (pop),
      .rsp   (rsp)
   );

endmodule

/* hw/rtl/ecif_checker.sv */
// ----------------------------------------------------------------------------
// ecif_checker
// Port-level checks on the flux block, bound to the top level.
// ----------------------------------------------------------------------------
module ecif_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [ecif_pkg::DATA_W-1:0] rsp_mass_flux,
   input logic signed [ecif_pkg::DATA_W-1:0] rsp_momentum_flux,
   input logic signed [ecif_pkg::DATA_W-1:0] rsp_energy_flux,
   input logic                               rsp_density_fault
);

   // a stalled result beat keeps its flux values
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mass_flux)
         && $stable(rsp_momentum_flux) && $stable(rsp_energy_flux))
      else $error("rsp beat changed while stalled");

   // bad density gives zero momentum and energy flux
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_density_fault |-> rsp_momentum_flux == '0 && rsp_energy_flux == '0)
      else $error("density fault with nonzero flux");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind euler_central_interface_flux ecif_checker u_ecif_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp.valid),
   .rsp_ready         (rsp.ready),
   .rsp_mass_flux     (rsp.mass_flux),
   .rsp_momentum_flux (rsp.momentum_flux),
   .rsp_energy_flux   (rsp.energy_flux),
   .rsp_density_fault (rsp.density_fault)
);

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Streams boundary and cell beats into the Euler interface flux block. Each
// accepted beat is run through a local fixed-point face flux model, and every
// flux beat is checked in order. Gamma is rewritten between phases, and both
// channels idle at random.
// ----------------------------------------------------------------------------
module tb;

   localparam logic [ecif_pkg::FUNC_W-1:0] FUNC_SPARE = 2'd3;
   localparam int  FRAC      = 24;
   localparam int  DRAIN_CYC = 400;
   localparam int  WD_LIMIT  = 20000;
   localparam longint LIM_P  = (longint'(1) <<< 47) - 1;
   localparam longint LIM_N  = -(longint'(1) <<< 47);

   typedef struct {
      logic signed [ecif_pkg::DATA_W-1:0] mass;
      logic signed [ecif_pkg::DATA_W-1:0] mom;
      logic signed [ecif_pkg::DATA_W-1:0] energy;
      logic                               fault;
   } flux_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [ecif_pkg::GAMMA_W-1:0] csr_wdata;

   ecif_req_if req_if ();
   ecif_rsp_if rsp_if ();

   euler_central_interface_flux u_top (
      .clock    (clock),
      .reset    (reset),
      .req      (req_if),
      .rsp      (rsp_if),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata)
   );

   // model state
   logic [ecif_pkg::GAMMA_W-1:0] gamma_cfg;
   longint             held_cell[3];
   bit                 held_ok;
   flux_type           flux_due[$];
   int                 errors;
   int                 beats_sent;
   int                 idle_pct;
   int                 wd_count;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint sat48(longint x);
      if (x > LIM_P) return LIM_P;
      if (x < LIM_N) return LIM_N;
      return x;
   endfunction

   function automatic longint clamp_mag(bit neg, logic [95:0] v);
      logic [95:0] lim;
      lim = neg ? 96'(longint'(1) <<< 47) : 96'(LIM_P);
      if (v > lim) v = lim;
      return neg ? -longint'(v[63:0]) : longint'(v[63:0]);
   endfunction

   function automatic longint q_mul(longint a, longint b);
      logic [95:0] ma;
      logic [95:0] mb;
      ma = 96'(a < 0 ? -a : a);
      mb = 96'(b < 0 ? -b : b);
      return clamp_mag((a < 0) != (b < 0), (ma * mb) >> FRAC);
   endfunction

   function automatic longint q_div(longint a, longint b);
      logic [95:0] ma;
      logic [95:0] mb;
      if (b == 0) return a > 0 ? LIM_P : (a < 0 ? LIM_N : 0);
      ma = 96'(a < 0 ? -a : a);
      mb = 96'(b < 0 ? -b : b);
      return clamp_mag((a < 0) != (b < 0), (ma << FRAC) / mb);
   endfunction

   function automatic flux_type face_flux(longint r, longint m, longint e);
      longint   one;
      longint   g;
      longint   c3;
      longint   g1;
      longint   gh;
      longint   u;
      longint   q;
      longint   inner;
      flux_type f;
      one = longint'(1) <<< FRAC;
      g   = longint'(gamma_cfg);
      c3  = (3 * one - g) / 2;
      g1  = g - one;
      gh  = g1 / 2;
      f.mass = m[ecif_pkg::DATA_W-1:0];
      if (r <= 0) begin
         f.mom    = '0;
         f.energy = '0;
         f.fault  = 1'b1;
         return f;
      end
      u      = q_div(m, r);
      q      = q_mul(m, u);
      inner  = sat48(q_mul(g1, e) - q_mul(gh, q));
      f.mom    = 48'(sat48(q_mul(c3, q) + q_mul(g1, e)));
      f.energy = 48'(sat48(q_mul(e, u) + q_mul(u, inner)));
      f.fault  = 1'b0;
      return f;
   endfunction

   // update the model for one accepted beat, queue the flux it causes
   task automatic predict_beat(logic [ecif_pkg::FUNC_W-1:0] fn,
                               logic signed [ecif_pkg::DATA_W-1:0] a,
                               logic signed [ecif_pkg::DATA_W-1:0] b,
                               logic signed [ecif_pkg::DATA_W-1:0] c);
      longint ra;
      longint rb;
      longint rc;
      longint m;
      longint e;
      ra = a;
      rb = b;
      rc = c;
      if (fn == ecif_pkg::FUNC_LEFT || fn == ecif_pkg::FUNC_RIGHT) begin
         m = q_mul(ra, rb);
         e = sat48(q_div(rc, longint'(gamma_cfg) - (longint'(1) <<< FRAC))
                   + q_mul(m, rb) / 2);
         flux_due.push_back(face_flux(ra, m, e));
         held_ok = 1'b0;
      end else if (fn == ecif_pkg::FUNC_CELL) begin
         if (held_ok)
            flux_due.push_back(face_flux((ra + held_cell[0]) / 2,
                                         (rb + held_cell[1]) / 2,
                                         (rc + held_cell[2]) / 2));
         held_cell[0] = ra;
         held_cell[1] = rb;
         held_cell[2] = rc;
         held_ok = 1'b1;
      end
   endtask

   task automatic send_beat(logic [ecif_pkg::FUNC_W-1:0] fn,
                            logic signed [ecif_pkg::DATA_W-1:0] a,
                            logic signed [ecif_pkg::DATA_W-1:0] b,
                            logic signed [ecif_pkg::DATA_W-1:0] c);
      while ($urandom_range(99) < idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.func    <= fn;
      req_if.value_a <= a;
      req_if.value_b <= b;
      req_if.value_c <= c;
      do @(posedge clock); while (!req_if.ready);
      predict_beat(fn, a, b, c);
      beats_sent++;
   endtask

   task automatic drain;
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (flux_due.size() != 0) @(posedge clock);
      // a first cell gives no flux but may still be in flight
      repeat (DRAIN_CYC) @(posedge clock);
   endtask

   task automatic write_gamma(logic [ecif_pkg::GAMMA_W-1:0] v);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
      gamma_cfg = v;
   endtask

   function automatic logic signed [ecif_pkg::DATA_W-1:0] any_value();
      case ($urandom_range(5))
         0: return ecif_pkg::DATA_W'({$urandom, $urandom});
         1: return $urandom_range(1) ? ecif_pkg::POS_LIM : ecif_pkg::NEG_LIM;
         2: return ecif_pkg::DATA_W'($signed($urandom));
         3: return ecif_pkg::DATA_W'($signed($urandom_range(1 << 27)) - (1 << 26));
         default: return ecif_pkg::DATA_W'($urandom_range(1 << 28, 1 << 22));
      endcase
   endfunction

   function automatic logic signed [ecif_pkg::DATA_W-1:0] density();
      if ($urandom_range(19) == 0) return any_value();
      return ecif_pkg::DATA_W'($urandom_range(1 << 30, 1 << 21));
   endfunction

   function automatic logic signed [ecif_pkg::DATA_W-1:0] moderate();
      if ($urandom_range(9) == 0) return any_value();
      return ecif_pkg::DATA_W'($signed($urandom_range(1 << 29)) - (1 << 28));
   endfunction

   // left boundary, a run of cells, right boundary
   task automatic send_row();
      int n;
      n = $urandom_range(8);
      send_beat(ecif_pkg::FUNC_LEFT, density(), moderate(), density());
      repeat (n) send_beat(ecif_pkg::FUNC_CELL, density(), moderate(), density());
      send_beat(ecif_pkg::FUNC_RIGHT, density(), moderate(), density());
   endtask

   task automatic test_directed();
      send_beat(ecif_pkg::FUNC_LEFT, 48'sh1000000, 48'sh800000, 48'sh1000000);
      send_beat(ecif_pkg::FUNC_LEFT, ecif_pkg::POS_LIM, ecif_pkg::POS_LIM, ecif_pkg::POS_LIM);
      send_beat(ecif_pkg::FUNC_LEFT, ecif_pkg::NEG_LIM, ecif_pkg::NEG_LIM, ecif_pkg::NEG_LIM);
      send_beat(ecif_pkg::FUNC_LEFT, '0, 48'sh1000000, 48'sh1000000);
      send_beat(ecif_pkg::FUNC_RIGHT, -48'sh1000000, 48'sh1000000, 48'sh1000000);
      send_beat(ecif_pkg::FUNC_CELL, 48'sh1000000, 48'sh400000, 48'sh2000000);
      send_beat(ecif_pkg::FUNC_CELL, 48'sh2000000, -48'sh400000, 48'sh3000000);
      send_beat(FUNC_SPARE, ecif_pkg::POS_LIM, ecif_pkg::NEG_LIM, '1);
      send_beat(ecif_pkg::FUNC_CELL, -48'sh2000000, 48'sh100000, 48'sh1000000);
      send_beat(ecif_pkg::FUNC_CELL, ecif_pkg::POS_LIM, ecif_pkg::POS_LIM, ecif_pkg::POS_LIM);
      send_beat(ecif_pkg::FUNC_CELL, ecif_pkg::POS_LIM, ecif_pkg::POS_LIM, ecif_pkg::POS_LIM);
      send_beat(ecif_pkg::FUNC_CELL, ecif_pkg::NEG_LIM, ecif_pkg::NEG_LIM, ecif_pkg::NEG_LIM);
      send_beat(ecif_pkg::FUNC_CELL, 48'sh1, ecif_pkg::NEG_LIM, ecif_pkg::POS_LIM);
      send_beat(ecif_pkg::FUNC_RIGHT, 48'sh1, ecif_pkg::POS_LIM, '0);
      send_beat(ecif_pkg::FUNC_CELL, 48'sh3000000, 48'sh1000000, 48'sh5000000);
   endtask

   task automatic test_gamma_extremes();
      // gamma of one: boundary energy divides by zero
      write_gamma(26'd16777216);
      send_beat(ecif_pkg::FUNC_LEFT, 48'sh1000000, 48'sh1000000, 48'sh1000000);
      send_beat(ecif_pkg::FUNC_LEFT, 48'sh1000000, 48'sh1000000, -48'sh1000000);
      send_beat(ecif_pkg::FUNC_RIGHT, 48'sh1000000, 48'sh1000000, '0);
      send_row();
      write_gamma(26'd50331648);
      send_beat(ecif_pkg::FUNC_LEFT, 48'sh1000000, 48'sh1000000, 48'sh1000000);
      send_row();
      write_gamma('1);
      send_row();
      write_gamma('0);
      send_row();
   endtask

   task automatic test_random(int target);
      while (beats_sent < target) begin
         case ($urandom_range(9))
            0: send_beat(2'($urandom), any_value(), any_value(), any_value());
            1: send_beat(ecif_pkg::FUNC_CELL, density(), moderate(), density());
            default: send_row();
         endcase
      end
   endtask

   task automatic test_pressure();
      send_row();
      drain();
      send_row();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (flux_due.size() == 0) begin
            $display("%0t: unexpected flux beat mass=%h", $time, rsp_if.mass_flux);
            errors++;
         end else begin
            flux_type f;
            f = flux_due.pop_front();
            if (f.mass !== rsp_if.mass_flux || f.mom !== rsp_if.momentum_flux ||
                f.energy !== rsp_if.energy_flux || f.fault !== rsp_if.density_fault) begin
               $display("%0t: mismatch expected %h %h %h %b actual %h %h %h %b", $time,
                        f.mass, f.mom, f.energy, f.fault, rsp_if.mass_flux,
                        rsp_if.momentum_flux, rsp_if.energy_flux, rsp_if.density_fault);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         wd_count <= 0;
      end else begin
         wd_count <= wd_count + 1;
         if (wd_count >= WD_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin
      errors     = 0;
      beats_sent = 0;
      idle_pct   = 8;
      held_ok    = 1'b0;
      held_cell  = '{0, 0, 0};
      gamma_cfg  = ecif_pkg::GAMMA_RESET;
      reset          <= 1'b1;
      csr_we         <= 1'b0;
      csr_wdata      <= '0;
      req_if.valid   <= 1'b0;
      req_if.func    <= '0;
      req_if.value_a <= '0;
      req_if.value_b <= '0;
      req_if.value_c <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_gamma_extremes();
      write_gamma(ecif_pkg::GAMMA_RESET);
      test_pressure();
      // stretch with no idling on either side
      idle_pct = 0;
      test_random(beats_sent + 120);
      idle_pct = 8;
      write_gamma(26'($urandom_range(50331648, 16777216)));
      test_random(beats_sent + 250);
      write_gamma(26'($urandom));
      test_random(beats_sent + 250);
      drain();
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/ecif_pkg.sv
hw/rtl/ecif_if.sv
hw/rtl/ecif_front.sv
hw/rtl/ecif_queue.sv
hw/rtl/ecif_arith.sv
hw/rtl/ecif_back.sv
hw/rtl/euler_central_interface_flux.sv
hw/rtl/ecif_checker.sv
tb/tb.sv
